FILE: rtl/core/pbpr_pkg.sv
package pbpr_pkg;

	localparam int unsigned MAX_GROUPS = 256;
	localparam int unsigned MAX_LINES  = 4096;
	localparam int unsigned MAX_PLANES = 24;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned WORD_W  = 16;
	localparam int unsigned ADDR_W  = 25;
	localparam int unsigned BPP_W   = 5;
	localparam int unsigned GRP_W   = 9;
	localparam int unsigned LINES_W = 13;
	localparam int unsigned CFG_W   = 13;
	localparam int unsigned IDX_W   = 2;
	localparam int unsigned LIDX_W  = 12;
	localparam int unsigned GIDX_W  = 8;
	localparam int unsigned PIDX_W  = 5;
	localparam int unsigned ROW_W   = 21;

	localparam logic [IDX_W-1:0] REG_BPP    = 2'd0;
	localparam logic [IDX_W-1:0] REG_GROUPS = 2'd1;
	localparam logic [IDX_W-1:0] REG_LINES  = 2'd2;

	localparam logic [BYTE_W-1:0] CTRL_NOP = 8'd128;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PUSH,
		ST_MUL,
		ST_END
	} pbpr_state_t;

	function automatic logic [BPP_W-1:0] clamp_planes(input logic [BPP_W-1:0] v);
		logic [BPP_W-1:0] r;
		if (v == '0) begin
			r = BPP_W'(1);
		end else if (v > BPP_W'(MAX_PLANES)) begin
			r = BPP_W'(MAX_PLANES);
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [GRP_W-1:0] clamp_groups(input logic [GRP_W-1:0] v);
		logic [GRP_W-1:0] r;
		if (v == '0) begin
			r = GRP_W'(1);
		end else if (v > GRP_W'(MAX_GROUPS)) begin
			r = GRP_W'(MAX_GROUPS);
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [LINES_W-1:0] clamp_lines(input logic [LINES_W-1:0] v);
		logic [LINES_W-1:0] r;
		if (v == '0) begin
			r = LINES_W'(1);
		end else if (v > LINES_W'(MAX_LINES)) begin
			r = LINES_W'(MAX_LINES);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/packbits_plane_reorder_decoder.sv
// PackBits decoder that writes decoded 16-bit words into an interleaved plane image.
// Input channel: in_valid/in_stall carry one compressed byte per word (in_byte) with
// stream_end marking the last byte available. in_stall is high while a byte is being
// worked on; the block takes one byte at a time.
// Output channel: out_valid/out_stall carry one decoded word with its word address,
// end_of_run on the last word caused by an input byte, image_done on the word that
// completes the image and truncated when the stream ended early.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 planes, 1 groups
// per line, 2 lines); the user must write while the block is idle, which it does not enforce.
// Steps: a byte is taken in the idle state; the push state skips a control byte, holds
// the first byte of a pair or pairs the second with it and forms the row, the mul state
// finishes the address and commits the word, and the end state closes the byte's run.
// A repeat run repeats hold, pair and finish for each word, set by the two-step address
// multiply (line*groups+group, then *planes+plane) on one shared multiplier.
// One word is held back until the next word or the end of the byte's run is known.
// If out_stall is high the sequencer waits with the word it holds; nothing is lost.
// Reset clears all run, pairing and position state and sets every configuration register to 1.
// After the image completes or the stream ends, bytes are taken and dropped.
module packbits_plane_reorder_decoder (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [7:0]                in_byte,
	input  logic                      stream_end,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      word_valid,
	output logic [15:0]               word_value,
	output logic [24:0]               word_address,
	output logic                      end_of_run,
	output logic                      image_done,
	output logic                      truncated,
	input  logic                      cfg_we,
	input  logic [pbpr_pkg::IDX_W-1:0] cfg_index,
	input  logic [pbpr_pkg::CFG_W-1:0] cfg_data
);
	import pbpr_pkg::*;

	pbpr_state_t state_q, state_next;

	logic [BPP_W-1:0]   bpp_q;
	logic [GRP_W-1:0]   groups_q;
	logic [LINES_W-1:0] lines_q;

	logic [BYTE_W-1:0] run_remaining_q;
	logic              awaiting_q;
	logic [BYTE_W-1:0] pending_q;
	logic              pending_valid_q;
	logic [LIDX_W-1:0] line_q;
	logic [PIDX_W-1:0] plane_q;
	logic [GIDX_W-1:0] group_q;
	logic              finished_q;

	logic [BYTE_W-1:0] byte_q;
	logic [BYTE_W-1:0] cnt_q;
	logic              last_q;
	logic [ROW_W-1:0]  row_q;
	logic [WORD_W-1:0] pair_q;

	logic              hold_full_q;
	logic [WORD_W-1:0] hold_value_q;
	logic [ADDR_W-1:0] hold_addr_q;
	logic              hold_done_q;

	logic              out_valid_q;
	logic              out_word_valid_q;
	logic [WORD_W-1:0] out_value_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic              out_eor_q;
	logic              out_done_q;
	logic              out_trunc_q;

	logic [BPP_W-1:0]   planes;
	logic [GRP_W-1:0]   groups;
	logic [LINES_W-1:0] lines;

	logic accept, out_free, push_skip, mul_go, end_need_out, end_go;
	logic do_take, do_half, do_pair, do_commit, do_end;

	logic [ROW_W-1:0]   mul_a;
	logic [GRP_W-1:0]   mul_b;
	logic [GRP_W-1:0]   mul_c;
	logic [ADDR_W:0]    mul_y;
	logic [GRP_W-1:0]   group_inc;
	logic [PIDX_W:0]    plane_inc;
	logic [LINES_W-1:0] line_inc;
	logic [GIDX_W-1:0]  group_nx;
	logic [PIDX_W-1:0]  plane_nx;
	logic [LIDX_W-1:0]  line_nx;
	logic               finished_nx;

	assign planes = clamp_planes(bpp_q);
	assign groups = clamp_groups(groups_q);
	assign lines  = clamp_lines(lines_q);

	assign in_stall   = (state_q != ST_IDLE);
	assign accept     = in_valid && (state_q == ST_IDLE);
	assign out_free   = !out_valid_q || !out_stall;
	assign push_skip  = (cnt_q == '0) || finished_q;
	assign mul_go     = !hold_full_q || out_free;
	assign end_need_out = hold_full_q || (last_q && !finished_q);
	assign end_go     = !end_need_out || out_free;

	// one multiplier: row while pairing, address in the next cycle
	assign mul_a = (state_q == ST_MUL) ? row_q : ROW_W'(line_q);
	assign mul_b = (state_q == ST_MUL) ? GRP_W'(planes) : groups;
	assign mul_c = (state_q == ST_MUL) ? GRP_W'(plane_q) : GRP_W'(group_q);
	assign mul_y = (ADDR_W+1)'(mul_a) * (ADDR_W+1)'(mul_b) + (ADDR_W+1)'(mul_c);

	always_comb begin
		group_inc   = GRP_W'(group_q) + GRP_W'(1);
		plane_inc   = (PIDX_W+1)'(plane_q) + (PIDX_W+1)'(1);
		line_inc    = LINES_W'(line_q) + LINES_W'(1);
		group_nx    = group_inc[GIDX_W-1:0];
		plane_nx    = plane_q;
		line_nx     = line_q;
		finished_nx = finished_q;
		if (group_inc >= groups) begin
			group_nx = '0;
			plane_nx = plane_inc[PIDX_W-1:0];
			if (plane_inc >= (PIDX_W+1)'(planes)) begin
				plane_nx = '0;
				line_nx  = line_inc[LIDX_W-1:0];
				if (line_inc >= lines) begin
					line_nx     = '0;
					finished_nx = 1'b1;
				end
			end
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && !finished_q) begin
					state_next = ST_PUSH;
				end
			end
			ST_PUSH: begin
				if (push_skip) begin
					state_next = ST_END;
				end else if (pending_valid_q) begin
					state_next = ST_MUL;
				end
			end
			ST_MUL: begin
				if (mul_go) begin
					state_next = ST_PUSH;
				end
			end
			ST_END: begin
				if (end_go) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		do_take   = 1'b0;
		do_half   = 1'b0;
		do_pair   = 1'b0;
		do_commit = 1'b0;
		do_end    = 1'b0;
		unique case (state_q)
			ST_IDLE: do_take = accept && !finished_q;
			ST_PUSH: begin
				do_half = !push_skip && !pending_valid_q;
				do_pair = !push_skip && pending_valid_q;
			end
			ST_MUL:  do_commit = mul_go;
			ST_END:  do_end = end_go;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			bpp_q           <= BPP_W'(1);
			groups_q        <= GRP_W'(1);
			lines_q         <= LINES_W'(1);
			run_remaining_q <= '0;
			awaiting_q      <= 1'b0;
			pending_q       <= '0;
			pending_valid_q <= 1'b0;
			line_q          <= '0;
			plane_q         <= '0;
			group_q         <= '0;
			finished_q      <= 1'b0;
			cnt_q           <= '0;
			last_q          <= 1'b0;
			hold_full_q     <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			state_q <= state_next;

			if (cfg_we) begin
				unique case (cfg_index)
					REG_BPP:    bpp_q    <= cfg_data[BPP_W-1:0];
					REG_GROUPS: groups_q <= cfg_data[GRP_W-1:0];
					REG_LINES:  lines_q  <= cfg_data;
					default: ;
				endcase
			end

			out_valid_q <= (out_valid_q && out_stall) || (do_commit && hold_full_q) ||
				(do_end && end_need_out);

			if (do_take) begin
				last_q <= stream_end;
				if (awaiting_q) begin
					cnt_q           <= run_remaining_q;
					awaiting_q      <= 1'b0;
					run_remaining_q <= '0;
				end else if (run_remaining_q != '0) begin
					cnt_q           <= BYTE_W'(1);
					run_remaining_q <= run_remaining_q - BYTE_W'(1);
				end else begin
					cnt_q <= '0;
					if (in_byte < CTRL_NOP) begin
						run_remaining_q <= {1'b0, in_byte[6:0]} + BYTE_W'(1);
					end else if (in_byte > CTRL_NOP) begin
						run_remaining_q <= BYTE_W'(9'd257 - {1'b0, in_byte});
						awaiting_q      <= 1'b1;
					end
				end
			end

			if (do_half) begin
				pending_q       <= byte_q;
				pending_valid_q <= 1'b1;
				cnt_q           <= cnt_q - BYTE_W'(1);
			end

			if (do_pair) begin
				pending_valid_q <= 1'b0;
			end

			if (do_commit) begin
				cnt_q       <= cnt_q - BYTE_W'(1);
				hold_full_q <= 1'b1;
				group_q     <= group_nx;
				plane_q     <= plane_nx;
				line_q      <= line_nx;
				finished_q  <= finished_nx;
			end

			if (do_end) begin
				hold_full_q <= 1'b0;
				if (last_q) begin
					finished_q      <= 1'b1;
					pending_valid_q <= 1'b0;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (do_take) begin
			byte_q <= in_byte;
		end
		if (do_pair) begin
			pair_q <= {pending_q, byte_q};
			row_q  <= mul_y[ROW_W-1:0];
		end
		if (do_commit) begin
			hold_value_q <= pair_q;
			hold_addr_q  <= mul_y[ADDR_W-1:0];
			hold_done_q  <= finished_nx;
			if (hold_full_q) begin
				out_word_valid_q <= 1'b1;
				out_value_q      <= hold_value_q;
				out_addr_q       <= hold_addr_q;
				out_eor_q        <= 1'b0;
				out_done_q       <= hold_done_q;
				out_trunc_q      <= 1'b0;
			end
		end
		if (do_end && end_need_out) begin
			out_eor_q   <= 1'b1;
			out_trunc_q <= last_q && !finished_q;
			if (hold_full_q) begin
				out_word_valid_q <= 1'b1;
				out_value_q      <= hold_value_q;
				out_addr_q       <= hold_addr_q;
				out_done_q       <= hold_done_q;
			end else begin
				out_word_valid_q <= 1'b0;
				out_value_q      <= '0;
				out_addr_q       <= '0;
				out_done_q       <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign word_valid   = out_word_valid_q;
	assign word_value   = out_value_q;
	assign word_address = out_addr_q;
	assign end_of_run   = out_eor_q;
	assign image_done   = out_done_q;
	assign truncated    = out_trunc_q;

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
	import pbpr_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned SETTLE      = 150;
	localparam int unsigned HOLD_CYCLES = 300;

	typedef struct {
		logic        wv;
		logic [15:0] value;
		logic [24:0] addr;
		logic        eor;
		logic        done;
		logic        trunc;
	} word_t;

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              in_valid   = 1'b0;
	logic              in_stall;
	logic [7:0]        in_byte    = '0;
	logic              stream_end = 1'b0;
	logic              out_valid;
	logic              out_stall  = 1'b0;
	logic              word_valid;
	logic [15:0]       word_value;
	logic [24:0]       word_address;
	logic              end_of_run;
	logic              image_done;
	logic              truncated;
	logic              cfg_we     = 1'b0;
	logic [IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_W-1:0]  cfg_data   = '0;

	// decoder state kept alongside the block
	logic [BPP_W-1:0]   cfg_bpp    = BPP_W'(1);
	logic [GRP_W-1:0]   cfg_groups = GRP_W'(1);
	logic [LINES_W-1:0] cfg_lines  = LINES_W'(1);
	int unsigned        run_left   = 0;
	bit                 value_next = 1'b0;
	logic [7:0]         held_byte  = '0;
	bit                 held_ok    = 1'b0;
	int unsigned        line_pos   = 0;
	int unsigned        plane_pos  = 0;
	int unsigned        group_pos  = 0;
	bit                 image_over = 1'b0;

	word_t       words_due[$];
	int unsigned faults      = 0;
	int unsigned cycle_count = 0;
	int unsigned hold_left   = 0;
	bit          hold_req    = 1'b0;
	bit          quiet       = 1'b0;

	packbits_plane_reorder_decoder u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_byte      (in_byte),
		.stream_end   (stream_end),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.word_valid   (word_valid),
		.word_value   (word_value),
		.word_address (word_address),
		.end_of_run   (end_of_run),
		.image_done   (image_done),
		.truncated    (truncated),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int unsigned limit_of(input int unsigned v, input int unsigned top);
		if (v == 0) begin
			return 1;
		end
		return (v > top) ? top : v;
	endfunction

	function automatic void pair_byte(input logic [7:0] b, ref word_t fresh[$]);
		int unsigned     planes;
		int unsigned     groups;
		int unsigned     lines;
		longint unsigned addr;
		word_t           w;
		if (image_over) begin
			return;
		end
		if (!held_ok) begin
			held_byte = b;
			held_ok = 1'b1;
			return;
		end
		held_ok = 1'b0;
		planes = limit_of(32'(cfg_bpp), MAX_PLANES);
		groups = limit_of(32'(cfg_groups), MAX_GROUPS);
		lines = limit_of(32'(cfg_lines), MAX_LINES);
		addr = (64'(line_pos) * 64'(groups) + 64'(group_pos)) * 64'(planes) +
			64'(plane_pos);
		w.wv = 1'b1;
		w.value = {held_byte, b};
		w.addr = addr[24:0];
		w.eor = 1'b0;
		w.trunc = 1'b0;
		// group, then plane, then line
		group_pos++;
		if (group_pos >= groups) begin
			group_pos = 0;
			plane_pos++;
			if (plane_pos >= planes) begin
				plane_pos = 0;
				line_pos++;
				if (line_pos >= lines) begin
					line_pos = 0;
					image_over = 1'b1;
				end
			end
		end
		w.done = image_over;
		fresh.push_back(w);
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic last);
		word_t       fresh[$];
		word_t       w;
		int unsigned n;
		if (image_over) begin
			return;
		end
		if (value_next) begin
			n = run_left;
			value_next = 1'b0;
			run_left = 0;
			repeat (n) pair_byte(b, fresh);
		end else if (run_left > 0) begin
			run_left--;
			pair_byte(b, fresh);
		end else if (b < CTRL_NOP) begin
			run_left = 32'(b) + 1;
		end else if (b > CTRL_NOP) begin
			run_left = 257 - 32'(b);
			value_next = 1'b1;
		end
		if (fresh.size() > 0) begin
			w = fresh.pop_back();
			w.eor = 1'b1;
			fresh.push_back(w);
		end
		if (last && !image_over) begin
			// stream cut short
			image_over = 1'b1;
			held_ok = 1'b0;
			if (fresh.size() > 0) begin
				w = fresh.pop_back();
				w.trunc = 1'b1;
				fresh.push_back(w);
			end else begin
				w = '{wv: 1'b0, value: '0, addr: '0, eor: 1'b1, done: 1'b0, trunc: 1'b1};
				fresh.push_back(w);
			end
		end
		foreach (fresh[i]) begin
			words_due.push_back(fresh[i]);
		end
	endfunction

	function automatic void note_fault(input string msg);
		faults++;
		if (faults <= 10) begin
			$display("%0t: %s", $realtime, msg);
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		@(negedge clk);
		if (!quiet && $urandom_range(0, 99) < 6) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		stream_end <= last;
		do @(posedge clk); while (in_stall);
		decode_byte(b, last);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (words_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input int unsigned val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_BPP: begin
				cfg_bpp = val[BPP_W-1:0];
			end
			REG_GROUPS: begin
				cfg_groups = val[GRP_W-1:0];
			end
			REG_LINES: begin
				cfg_lines = val[LINES_W-1:0];
			end
			default: begin
			end
		endcase
	endtask

	task automatic write_shape(input int unsigned planes, input int unsigned groups,
			input int unsigned lines);
		write_reg(REG_BPP, planes);
		write_reg(REG_GROUPS, groups);
		write_reg(REG_LINES, lines);
	endtask

	// well-formed runs with random content, plus stray bytes
	task automatic send_mixed(input int unsigned budget);
		int unsigned sent;
		int unsigned pick;
		int unsigned n;
		sent = 0;
		while (sent < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				n = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 7);
				send_byte(n[7:0], 1'b0);
				repeat (n + 1) send_byte(8'($urandom_range(0, 255)), 1'b0);
				sent += n + 2;
			end else if (pick < 80) begin
				send_byte(8'($urandom_range(129, 255)), 1'b0);
				send_byte(8'($urandom_range(0, 255)), 1'b0);
				sent += 2;
			end else if (pick < 85) begin
				send_byte(CTRL_NOP, 1'b0);
				sent++;
			end else begin
				send_byte(8'($urandom_range(0, 255)), 1'b0);
				sent++;
			end
		end
	endtask

	task automatic test_directed();
		write_shape(0, 0, 8191);
		send_byte(CTRL_NOP, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hA5, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h3C, 1'b0);
		send_byte(8'h81, 1'b0);
		send_byte(8'hC3, 1'b0);
		send_byte(CTRL_NOP, 1'b0);
		send_byte(8'h02, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'hFE, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h81, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h03, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h0F, 1'b0);
		send_byte(8'hF0, 1'b0);
		drain();
	endtask

	task automatic test_wide_image();
		write_shape(24, 256, 4096);
		send_mixed(20);
		drain();
	endtask

	task automatic test_backpressure();
		write_shape(31, 511, 5000);
		@(posedge clk);
		hold_req = 1'b1;
		send_byte(8'h2F, 1'b0);
		repeat (48) send_byte(8'($urandom_range(0, 255)), 1'b0);
		send_byte(8'h81, 1'b0);
		send_byte(8'($urandom_range(0, 255)), 1'b0);
		drain();
	endtask

	task automatic test_quiet_stretch();
		write_shape(2, 3, 4096);
		quiet = 1'b1;
		send_mixed(20);
		drain();
		quiet = 1'b0;
	endtask

	task automatic test_random_shapes();
		int unsigned plane_opts [8];
		plane_opts = '{1, 2, 4, 8, 16, 24, 5, 27};
		repeat (2) begin
			write_shape(plane_opts[$urandom_range(0, 7)], $urandom_range(2, 300),
				$urandom_range(4096, 8191));
			send_mixed(15);
			drain();
		end
	endtask

	task automatic test_image_end();
		if ($urandom_range(0, 1) == 0) begin
			// shrink the image so a long repeat completes it
			write_shape($urandom_range(1, 4), $urandom_range(1, 3), 0);
			send_byte(8'h81, 1'b0);
			send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		end else begin
			send_mixed(12);
			send_byte(8'($urandom_range(0, 255)), 1'b1);
		end
		// ignored after the end
		repeat (3) send_byte(8'($urandom_range(0, 255)), 1'b1);
		send_byte(8'($urandom_range(0, 255)), 1'b0);
		drain();
	endtask

	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !quiet && ($urandom_range(0, 99) < 6);
		end
	end

	always @(posedge clk) begin
		word_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (words_due.size() == 0) begin
				note_fault($sformatf("unexpected word v=%0b %h @%h eor=%0b done=%0b trunc=%0b",
					word_valid, word_value, word_address, end_of_run, image_done, truncated));
			end else begin
				w = words_due.pop_front();
				if (word_valid !== w.wv || word_value !== w.value || word_address !== w.addr ||
						end_of_run !== w.eor || image_done !== w.done || truncated !== w.trunc) begin
					note_fault($sformatf({"word mismatch: expected v=%0b %h @%h eor=%0b done=%0b ",
						"trunc=%0b, got v=%0b %h @%h eor=%0b done=%0b trunc=%0b"},
						w.wv, w.value, w.addr, w.eor, w.done, w.trunc,
						word_valid, word_value, word_address, end_of_run, image_done, truncated));
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_wide_image();
		test_backpressure();
		test_quiet_stretch();
		test_random_shapes();
		test_image_end();
		if (faults == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

FILE: packbits_plane_reorder_decoder.f
rtl/core/pbpr_pkg.sv
rtl/core/packbits_plane_reorder_decoder.sv
dv/tb.sv
